FILE: rtl/assert_macros.svh
// Assertion macros shared by the meter ballistics RTL.
// Every macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define SLMB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// An implication within the same clock edge.
`define SLMB_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// An implication whose consequent is checked at the next clock edge.
`define SLMB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/slmb_pkg.sv
// Shared types and constants of the stereo level meter ballistics unit.
// Depends on nothing; the files that use it refer to it by scoped names.
`timescale 1ns / 1ps

package slmb_pkg;

   // Fixed field widths.
   localparam int DB_W        = 16;
   localparam int HEIGHT_W    = 17;
   localparam int COEFF_W     = 16;
   localparam int MAX_DB_W    = 13;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int MUL_B_W     = 20;
   localparam int ACC_W       = 34;

   // Arithmetic constants.
   localparam logic signed [DB_W-1:0] DB_FLOOR       = -16'sd25600;
   localparam logic signed [DB_W-1:0] DB_CEIL        = 16'sd32767;
   localparam logic signed [MUL_B_W-1:0] DB_PER_OCTAVE = 20'sd394566;
   localparam int                     DB_ROUND       = 1 << 23;
   localparam logic [HEIGHT_W-1:0]    FULL_SCALE     = 17'd65536;
   localparam logic [HEIGHT_W-1:0]    SNAP_LIMIT     = 17'd66;
   localparam logic [ACC_W-1:0]       ROUND_HALF     = 34'd32768;

   // Register reset values.
   localparam logic signed [DB_W-1:0] MIN_DB_RESET     = -16'sd17920;
   localparam logic [MAX_DB_W-1:0]    MAX_DB_RESET     = 13'd1536;
   localparam logic [COEFF_W-1:0]     NORM_SCALE_RESET = 16'd862;
   localparam logic [COEFF_W-1:0]     ATTACK_RESET     = 16'd45875;
   localparam logic [COEFF_W-1:0]     RELEASE_RESET    = 16'd62259;

   // Operation codes of an input item.
   typedef enum logic [1:0] {
      OP_LEVEL      = 2'd0,
      OP_TICK       = 2'd1,
      OP_PEAK_RESET = 2'd2,
      OP_BYPASS     = 2'd3
   } op_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MIN_DB     = 3'd0,
      REG_MAX_DB     = 3'd1,
      REG_NORM_SCALE = 3'd2,
      REG_ATTACK     = 3'd3,
      REG_RELEASE    = 3'd4
   } reg_index_type;

   // Operand pair fed to the shared multiplier.
   typedef enum logic [2:0] {
      MUL_DB     = 3'd0,
      MUL_NORM_L = 3'd1,
      MUL_NORM_R = 3'd2,
      MUL_OLD_L  = 3'd3,
      MUL_TGT_L  = 3'd4,
      MUL_OLD_R  = 3'd5,
      MUL_TGT_R  = 3'd6
   } mul_sel_type;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LOG_L,
      ST_LOG_R,
      ST_MDB_R,
      ST_DB_L,
      ST_DB_R,
      ST_NRM_R,
      ST_NRM_L,
      ST_UPDATE,
      ST_SM_L1,
      ST_SM_L2,
      ST_SM_R1,
      ST_SM_R2,
      ST_SM_W1,
      ST_SM_W2,
      ST_MISC,
      ST_DONE
   } state_type;

   // Datapath controls driven by the sequencer.
   typedef struct packed {
      logic        log_load;
      logic        log_right;
      logic        mul_load;
      mul_sel_type mul_sel;
      logic        db_store_l;
      logic        db_store_r;
      logic        norm_store_l;
      logic        target_update;
      logic        acc_load;
      logic        shown_store_l;
      logic        shown_store_r;
      logic        misc_apply;
      logic        rsp_load;
   } ctrl_type;

endpackage

FILE: rtl/slmb_if.sv
// Channel interfaces of the meter ballistics unit: the request and the response item.
// Depends on slmb_pkg for the fixed field widths.
`timescale 1ns / 1ps

interface slmb_req_if #(
   parameter int LEVEL_BITS = 16
);
   logic                  valid;
   logic                  ready;
   logic [1:0]            operation;
   logic [LEVEL_BITS-1:0] left_level;
   logic [LEVEL_BITS-1:0] right_level;
   logic                  bypass_on;

   modport source (output valid, operation, left_level, right_level, bypass_on, input ready);
   modport sink   (input valid, operation, left_level, right_level, bypass_on, output ready);
endinterface

interface slmb_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [slmb_pkg::HEIGHT_W-1:0]       left_display;
   logic [slmb_pkg::HEIGHT_W-1:0]       right_display;
   logic [slmb_pkg::HEIGHT_W-1:0]       peak_height;
   logic signed [slmb_pkg::DB_W-1:0]    peak_decibels;
   logic                                peak_over;

   modport source (output valid, left_display, right_display, peak_height, peak_decibels,
                   peak_over, input ready);
   modport sink   (input valid, left_display, right_display, peak_height, peak_decibels,
                   peak_over, output ready);
endinterface

FILE: rtl/slmb_log2.sv
// Table-based log2 of a linear magnitude: leading-one register stage, then table lookup.
// Depends on nothing but its parameters; the table is built at elaboration.
`timescale 1ns / 1ps

module slmb_log2 #(
   parameter int LEVEL_BITS      = 16,
   parameter int LOG_TABLE_DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        load,
   input  logic [LEVEL_BITS-1:0]                       level,
   output logic signed [$clog2(LEVEL_BITS)+16:0]       log2_value
);

   localparam int FRAC_BITS = LEVEL_BITS - 2;
   localparam int E_W       = $clog2(LEVEL_BITS);
   localparam int MANT_W    = LEVEL_BITS - 1;
   localparam int IDX_W     = $clog2(LOG_TABLE_DEPTH);
   localparam int DEPTH_W   = $clog2(LOG_TABLE_DEPTH + 1);
   localparam int PROD_W    = MANT_W + DEPTH_W;

   // log2(1 + entry/depth) in Q0.16, truncated, by repeated squaring.
   function automatic logic [15:0] log_frac_entry(input int unsigned entry);
      logic [63:0] x;
      logic [15:0] r;
      x = ((64'(LOG_TABLE_DEPTH) + 64'(entry)) << 30) / LOG_TABLE_DEPTH;
      r = '0;
      for (int k = 0; k < 16; k++) begin
         x = (x * x) >> 30;
         r = {r[14:0], 1'b0};
         if (x >= (64'd2 << 30)) begin
            x    = x >> 1;
            r[0] = 1'b1;
         end
      end
      return r;
   endfunction

   logic [15:0]        log_tab [LOG_TABLE_DEPTH];
   logic [E_W-1:0]     lead;
   logic [E_W-1:0]     shift_amt;
   logic [MANT_W:0]    shifted;
   logic [E_W-1:0]     exp_ff;
   logic [E_W-1:0]     exp_in;
   logic [MANT_W-1:0]  mant_ff;
   logic [MANT_W-1:0]  mant_in;
   logic [PROD_W-1:0]  idx_prod;
   logic [DEPTH_W-1:0] idx_full;
   logic [IDX_W-1:0]   idx;
   logic signed [E_W:0] int_part;

   // Constant table of fractional log2 values.
   for (genvar gi = 0; gi < LOG_TABLE_DEPTH; gi++) begin : g_tab
      localparam logic [15:0] ENTRY = log_frac_entry(gi);
      assign log_tab[gi] = ENTRY;
   end

   // Leading-one position; the highest set bit wins.
   always_comb begin
      lead = '0;
      for (int b = 0; b < LEVEL_BITS; b++) begin
         if (level[b]) begin
            lead = E_W'(b);
         end
      end
   end

   // Left-justify the magnitude so the bits below the leading one form the mantissa.
   assign shift_amt = E_W'(MANT_W) - lead;
   assign shifted   = level << shift_amt;
   assign exp_in    = lead;
   assign mant_in   = shifted[MANT_W-1:0];

   always_ff @(posedge clock) begin
      if (load) begin
         exp_ff  <= exp_in;
         mant_ff <= mant_in;
      end
   end

   // Table index is the mantissa scaled to the table depth, then integer and fraction join.
   assign idx_prod   = PROD_W'(mant_ff) * PROD_W'(LOG_TABLE_DEPTH);
   assign idx_full   = idx_prod[PROD_W-1:MANT_W];
   assign idx        = idx_full[IDX_W-1:0];
   assign int_part   = $signed({1'b0, exp_ff}) - (E_W+1)'(FRAC_BITS);
   assign log2_value = {int_part, log_tab[idx]};

endmodule

FILE: rtl/slmb_mul.sv
// Shared signed multiplier with registered operands and registered product.
// Depends on slmb_pkg for the width of the second operand.
`timescale 1ns / 1ps

module slmb_mul #(
   parameter int A_W = 21
) (
   input  logic                                      clock,
   input  logic                                      load,
   input  logic signed [A_W-1:0]                     a,
   input  logic signed [slmb_pkg::MUL_B_W-1:0]       b,
   output logic signed [A_W+slmb_pkg::MUL_B_W-1:0]   product
);

   localparam int P_W = A_W + slmb_pkg::MUL_B_W;

   logic signed [A_W-1:0]              a_ff;
   logic signed [slmb_pkg::MUL_B_W-1:0] b_ff;
   logic signed [P_W-1:0]              p_ff;
   logic signed [P_W-1:0]              p_in;

   // Operands are captured on load; the product register then captures their product.
   assign p_in = a_ff * b_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         a_ff <= a;
         b_ff <= b;
      end
      p_ff <= p_in;
   end

   assign product = p_ff;

endmodule

FILE: rtl/slmb_seq.sv
// Sequencer of the meter ballistics unit: steps the shared multiplier through an item.
// Depends on slmb_pkg for the state, operation and control types.
`timescale 1ns / 1ps

module slmb_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  slmb_pkg::op_type   op,
   input  logic               rsp_free,
   output logic               ready,
   output slmb_pkg::ctrl_type ctrl
);

   slmb_pkg::state_type state_ff;
   slmb_pkg::state_type state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         slmb_pkg::ST_IDLE: begin
            if (start) begin
               unique case (op)
                  slmb_pkg::OP_LEVEL:      state_in = slmb_pkg::ST_LOG_L;
                  slmb_pkg::OP_TICK:       state_in = slmb_pkg::ST_SM_L1;
                  slmb_pkg::OP_PEAK_RESET: state_in = slmb_pkg::ST_MISC;
                  slmb_pkg::OP_BYPASS:     state_in = slmb_pkg::ST_MISC;
                  default:                 state_in = slmb_pkg::ST_MISC;
               endcase
            end
         end
         slmb_pkg::ST_LOG_L:  state_in = slmb_pkg::ST_LOG_R;
         slmb_pkg::ST_LOG_R:  state_in = slmb_pkg::ST_MDB_R;
         slmb_pkg::ST_MDB_R:  state_in = slmb_pkg::ST_DB_L;
         slmb_pkg::ST_DB_L:   state_in = slmb_pkg::ST_DB_R;
         slmb_pkg::ST_DB_R:   state_in = slmb_pkg::ST_NRM_R;
         slmb_pkg::ST_NRM_R:  state_in = slmb_pkg::ST_NRM_L;
         slmb_pkg::ST_NRM_L:  state_in = slmb_pkg::ST_UPDATE;
         slmb_pkg::ST_UPDATE: state_in = slmb_pkg::ST_DONE;
         slmb_pkg::ST_SM_L1:  state_in = slmb_pkg::ST_SM_L2;
         slmb_pkg::ST_SM_L2:  state_in = slmb_pkg::ST_SM_R1;
         slmb_pkg::ST_SM_R1:  state_in = slmb_pkg::ST_SM_R2;
         slmb_pkg::ST_SM_R2:  state_in = slmb_pkg::ST_SM_W1;
         slmb_pkg::ST_SM_W1:  state_in = slmb_pkg::ST_SM_W2;
         slmb_pkg::ST_SM_W2:  state_in = slmb_pkg::ST_DONE;
         slmb_pkg::ST_MISC:   state_in = slmb_pkg::ST_DONE;
         slmb_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = slmb_pkg::ST_IDLE;
            end
         end
         default: state_in = slmb_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= slmb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Controls per state. The multiplier registers the operands, then the product.
   always_comb begin
      ctrl  = '0;
      ready = 1'b0;
      unique case (state_ff)
         slmb_pkg::ST_IDLE: begin
            ready = 1'b1;
         end
         slmb_pkg::ST_LOG_L: begin
            ctrl.log_load = 1'b1;
         end
         slmb_pkg::ST_LOG_R: begin
            ctrl.log_load  = 1'b1;
            ctrl.log_right = 1'b1;
            ctrl.mul_load  = 1'b1;
            ctrl.mul_sel   = slmb_pkg::MUL_DB;
         end
         slmb_pkg::ST_MDB_R: begin
            ctrl.mul_load = 1'b1;
            ctrl.mul_sel  = slmb_pkg::MUL_DB;
         end
         slmb_pkg::ST_DB_L: begin
            ctrl.db_store_l = 1'b1;
         end
         slmb_pkg::ST_DB_R: begin
            ctrl.db_store_r = 1'b1;
            ctrl.mul_load   = 1'b1;
            ctrl.mul_sel    = slmb_pkg::MUL_NORM_L;
         end
         slmb_pkg::ST_NRM_R: begin
            ctrl.mul_load = 1'b1;
            ctrl.mul_sel  = slmb_pkg::MUL_NORM_R;
         end
         slmb_pkg::ST_NRM_L: begin
            ctrl.norm_store_l = 1'b1;
         end
         slmb_pkg::ST_UPDATE: begin
            ctrl.target_update = 1'b1;
         end
         slmb_pkg::ST_SM_L1: begin
            ctrl.mul_load = 1'b1;
            ctrl.mul_sel  = slmb_pkg::MUL_OLD_L;
         end
         slmb_pkg::ST_SM_L2: begin
            ctrl.mul_load = 1'b1;
            ctrl.mul_sel  = slmb_pkg::MUL_TGT_L;
         end
         slmb_pkg::ST_SM_R1: begin
            ctrl.mul_load = 1'b1;
            ctrl.mul_sel  = slmb_pkg::MUL_OLD_R;
            ctrl.acc_load = 1'b1;
         end
         slmb_pkg::ST_SM_R2: begin
            ctrl.mul_load      = 1'b1;
            ctrl.mul_sel       = slmb_pkg::MUL_TGT_R;
            ctrl.shown_store_l = 1'b1;
         end
         slmb_pkg::ST_SM_W1: begin
            ctrl.acc_load = 1'b1;
         end
         slmb_pkg::ST_SM_W2: begin
            ctrl.shown_store_r = 1'b1;
         end
         slmb_pkg::ST_MISC: begin
            ctrl.misc_apply = 1'b1;
         end
         slmb_pkg::ST_DONE: begin
            ctrl.rsp_load = rsp_free;
         end
         default: begin
            ready = 1'b0;
         end
      endcase
   end

endmodule

FILE: rtl/stereo_level_meter_ballistics_unit.sv
// Top level of the stereo level meter ballistics unit: registers, datapath and result stage.
// Depends on slmb_pkg, slmb_req_if, slmb_rsp_if, slmb_log2, slmb_mul, slmb_seq and
// assert_macros.svh.
`timescale 1ns / 1ps

// Stereo meter ballistics with peak hold. Each request item carries an operation: a level
// update converts both magnitudes to dB, sets the channel targets and raises the peak hold, a
// display tick smooths both shown levels toward their targets, a peak reset clears the hold,
// and a bypass with bypass_on set clears both targets. Every item returns exactly one
// response item with the state after the operation. The block takes one item at a time and
// drops ready from the accepting edge until the response is loaded into the output register;
// the next item can be accepted while that response still waits. Level updates and display
// ticks need more states than the other items, as they use the single shared multiplier,
// whose product is registered after its operands. Configuration registers are written via
// csr_write_enable, csr_index and csr_write_data; the user must write them only while the
// block is idle, which it does not enforce. Indexes beyond the last register are ignored.

`include "assert_macros.svh"

module stereo_level_meter_ballistics_unit #(
   parameter int LEVEL_BITS      = 16,
   parameter int LOG_TABLE_DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    reset,
   slmb_req_if.sink                                req_chan,
   slmb_rsp_if.source                              rsp_chan,
   input  logic                                    csr_write_enable,
   input  logic [slmb_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [slmb_pkg::CSR_DATA_W-1:0]         csr_write_data
);

   localparam int L2_W  = $clog2(LEVEL_BITS) + 17;
   localparam int A_W   = (L2_W > 18) ? L2_W : 18;
   localparam int P_W   = A_W + slmb_pkg::MUL_B_W;
   localparam int DB_W  = slmb_pkg::DB_W;
   localparam int H_W   = slmb_pkg::HEIGHT_W;
   localparam int C_W   = slmb_pkg::COEFF_W;
   localparam int ACC_W = slmb_pkg::ACC_W;

   // Rounded and clamped dB from the log2 product; a zero magnitude reads as the floor.
   function automatic logic signed [DB_W-1:0] db_from_product(
      input logic signed [P_W-1:0] prod,
      input logic                  is_zero
   );
      logic signed [P_W-1:0] q;
      q = (prod + P_W'(slmb_pkg::DB_ROUND)) >>> 24;
      priority if (is_zero || (q < P_W'(slmb_pkg::DB_FLOOR))) begin
         return slmb_pkg::DB_FLOOR;
      end else if (q > P_W'(slmb_pkg::DB_CEIL)) begin
         return slmb_pkg::DB_CEIL;
      end else begin
         return q[DB_W-1:0];
      end
   endfunction

   // Height in Q1.16 from dB; the span bottom is tested before the top.
   function automatic logic [H_W-1:0] normalize(
      input logic signed [DB_W-1:0]            db,
      input logic signed [DB_W-1:0]            lo,
      input logic [slmb_pkg::MAX_DB_W-1:0]     hi,
      input logic [31:0]                       prod
   );
      logic [23:0] v;
      v = prod[31:8];
      priority if (db <= lo) begin
         return '0;
      end else if (db >= $signed({3'b000, hi})) begin
         return slmb_pkg::FULL_SCALE;
      end else if (v > 24'(slmb_pkg::FULL_SCALE)) begin
         return slmb_pkg::FULL_SCALE;
      end else begin
         return v[H_W-1:0];
      end
   endfunction

   // Final smoothing step: drop the fraction, clamp to full scale, snap tiny levels to zero.
   function automatic logic [H_W-1:0] smooth_finish(input logic [ACC_W-1:0] sum);
      logic [ACC_W-17:0] v;
      v = sum[ACC_W-1:16];
      priority if (v > (ACC_W-16)'(slmb_pkg::FULL_SCALE)) begin
         return slmb_pkg::FULL_SCALE;
      end else if (v < (ACC_W-16)'(slmb_pkg::SNAP_LIMIT)) begin
         return '0;
      end else begin
         return v[H_W-1:0];
      end
   endfunction

   // Configuration registers.
   logic signed [DB_W-1:0]              min_db_ff;
   logic signed [DB_W-1:0]              min_db_in;
   logic [slmb_pkg::MAX_DB_W-1:0]       max_db_ff;
   logic [slmb_pkg::MAX_DB_W-1:0]       max_db_in;
   logic [C_W-1:0]                      norm_scale_ff;
   logic [C_W-1:0]                      norm_scale_in;
   logic [C_W-1:0]                      attack_ff;
   logic [C_W-1:0]                      attack_in;
   logic [C_W-1:0]                      release_ff;
   logic [C_W-1:0]                      release_in;

   // Meter state.
   logic [H_W-1:0]                      target_left_ff;
   logic [H_W-1:0]                      target_left_in;
   logic [H_W-1:0]                      target_right_ff;
   logic [H_W-1:0]                      target_right_in;
   logic [H_W-1:0]                      shown_left_ff;
   logic [H_W-1:0]                      shown_left_in;
   logic [H_W-1:0]                      shown_right_ff;
   logic [H_W-1:0]                      shown_right_in;
   logic [H_W-1:0]                      held_height_ff;
   logic [H_W-1:0]                      held_height_in;
   logic signed [DB_W-1:0]              held_db_ff;
   logic signed [DB_W-1:0]              held_db_in;

   // Item and working registers.
   slmb_pkg::op_type                    item_op_ff;
   logic [LEVEL_BITS-1:0]               item_left_ff;
   logic [LEVEL_BITS-1:0]               item_right_ff;
   logic                                item_bypass_ff;
   logic signed [DB_W-1:0]              db_left_ff;
   logic signed [DB_W-1:0]              db_right_ff;
   logic [H_W-1:0]                      norm_left_ff;
   logic [ACC_W-1:0]                    acc_ff;
   logic [ACC_W-1:0]                    acc_in;

   // Result stage.
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic [H_W-1:0]                      rsp_left_ff;
   logic [H_W-1:0]                      rsp_right_ff;
   logic [H_W-1:0]                      rsp_height_ff;
   logic signed [DB_W-1:0]              rsp_db_ff;
   logic                                rsp_over_ff;

   // Control and datapath wires.
   slmb_pkg::ctrl_type                  ctrl;
   logic                                seq_ready;
   logic                                accept;
   logic                                rsp_free;
   logic [LEVEL_BITS-1:0]               log_level;
   logic signed [L2_W-1:0]              l2_value;
   logic signed [A_W-1:0]               mul_a;
   logic signed [slmb_pkg::MUL_B_W-1:0] mul_b;
   logic signed [P_W-1:0]               product;
   logic [C_W-1:0]                      coeff_left;
   logic [C_W-1:0]                      coeff_right;
   logic [H_W-1:0]                      inv_left;
   logic [H_W-1:0]                      inv_right;
   logic signed [DB_W:0]                diff_left;
   logic signed [DB_W:0]                diff_right;
   logic [H_W-1:0]                      norm_right;
   logic [H_W-1:0]                      norm_high;
   logic signed [DB_W-1:0]              db_high;
   logic [ACC_W-1:0]                    smooth_sum;
   logic                                heights_ok;
   logic                                target_write;

   assign accept         = req_chan.valid && seq_ready;
   assign req_chan.ready = seq_ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   slmb_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .op       (slmb_pkg::op_type'(req_chan.operation)),
      .rsp_free (rsp_free),
      .ready    (seq_ready),
      .ctrl     (ctrl)
   );

   // Log2 of one channel at a time.
   assign log_level = ctrl.log_right ? item_right_ff : item_left_ff;

   slmb_log2 #(
      .LEVEL_BITS      (LEVEL_BITS),
      .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
   ) u_log2 (
      .clock      (clock),
      .load       (ctrl.log_load),
      .level      (log_level),
      .log2_value (l2_value)
   );

   // Smoothing weights: attack when the target lies above the shown level.
   assign coeff_left  = (target_left_ff > shown_left_ff) ? attack_ff : release_ff;
   assign coeff_right = (target_right_ff > shown_right_ff) ? attack_ff : release_ff;
   assign inv_left    = slmb_pkg::FULL_SCALE - {1'b0, coeff_left};
   assign inv_right   = slmb_pkg::FULL_SCALE - {1'b0, coeff_right};
   assign diff_left   = (DB_W+1)'(db_left_ff) - (DB_W+1)'(min_db_ff);
   assign diff_right  = (DB_W+1)'(db_right_ff) - (DB_W+1)'(min_db_ff);

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (ctrl.mul_sel)
         slmb_pkg::MUL_DB: begin
            mul_a = A_W'(l2_value);
            mul_b = slmb_pkg::DB_PER_OCTAVE;
         end
         slmb_pkg::MUL_NORM_L: begin
            mul_a = A_W'(diff_left);
            mul_b = $signed({4'b0000, norm_scale_ff});
         end
         slmb_pkg::MUL_NORM_R: begin
            mul_a = A_W'(diff_right);
            mul_b = $signed({4'b0000, norm_scale_ff});
         end
         slmb_pkg::MUL_OLD_L: begin
            mul_a = A_W'($signed({1'b0, shown_left_ff}));
            mul_b = $signed({4'b0000, coeff_left});
         end
         slmb_pkg::MUL_TGT_L: begin
            mul_a = A_W'($signed({1'b0, target_left_ff}));
            mul_b = $signed({3'b000, inv_left});
         end
         slmb_pkg::MUL_OLD_R: begin
            mul_a = A_W'($signed({1'b0, shown_right_ff}));
            mul_b = $signed({4'b0000, coeff_right});
         end
         slmb_pkg::MUL_TGT_R: begin
            mul_a = A_W'($signed({1'b0, target_right_ff}));
            mul_b = $signed({3'b000, inv_right});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   slmb_mul #(
      .A_W (A_W)
   ) u_mul (
      .clock   (clock),
      .load    (ctrl.mul_load),
      .a       (mul_a),
      .b       (mul_b),
      .product (product)
   );

   // Level update results: right normalization arrives last, then peak hold decides.
   assign norm_right = normalize(db_right_ff, min_db_ff, max_db_ff, product[31:0]);
   assign norm_high  = (norm_left_ff > norm_right) ? norm_left_ff : norm_right;
   assign db_high    = (db_left_ff > db_right_ff) ? db_left_ff : db_right_ff;

   // Smoothing accumulator: first product plus rounding, then the second product.
   assign acc_in     = product[ACC_W-1:0] + slmb_pkg::ROUND_HALF;
   assign smooth_sum = acc_ff + product[ACC_W-1:0];

   // Configuration writes.
   always_comb begin
      min_db_in     = min_db_ff;
      max_db_in     = max_db_ff;
      norm_scale_in = norm_scale_ff;
      attack_in     = attack_ff;
      release_in    = release_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            slmb_pkg::REG_MIN_DB:     min_db_in     = csr_write_data;
            slmb_pkg::REG_MAX_DB:     max_db_in     = csr_write_data[slmb_pkg::MAX_DB_W-1:0];
            slmb_pkg::REG_NORM_SCALE: norm_scale_in = csr_write_data;
            slmb_pkg::REG_ATTACK:     attack_in     = csr_write_data;
            slmb_pkg::REG_RELEASE:    release_in    = csr_write_data;
            default:                  min_db_in     = min_db_ff;
         endcase
      end
   end

   // Meter state updates.
   always_comb begin
      target_left_in  = target_left_ff;
      target_right_in = target_right_ff;
      shown_left_in   = shown_left_ff;
      shown_right_in  = shown_right_ff;
      held_height_in  = held_height_ff;
      held_db_in      = held_db_ff;
      if (ctrl.target_update) begin
         target_left_in  = norm_left_ff;
         target_right_in = norm_right;
         if (norm_high > held_height_ff) begin
            held_height_in = norm_high;
            held_db_in     = db_high;
         end
      end
      if (ctrl.shown_store_l) begin
         shown_left_in = smooth_finish(smooth_sum);
      end
      if (ctrl.shown_store_r) begin
         shown_right_in = smooth_finish(smooth_sum);
      end
      if (ctrl.misc_apply) begin
         if (item_op_ff == slmb_pkg::OP_PEAK_RESET) begin
            held_height_in = '0;
            held_db_in     = min_db_ff;
         end else if (item_bypass_ff) begin
            target_left_in  = '0;
            target_right_in = '0;
         end
      end
   end

   // Result stage handshake.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_db_ff       <= slmb_pkg::MIN_DB_RESET;
         max_db_ff       <= slmb_pkg::MAX_DB_RESET;
         norm_scale_ff   <= slmb_pkg::NORM_SCALE_RESET;
         attack_ff       <= slmb_pkg::ATTACK_RESET;
         release_ff      <= slmb_pkg::RELEASE_RESET;
         target_left_ff  <= '0;
         target_right_ff <= '0;
         shown_left_ff   <= '0;
         shown_right_ff  <= '0;
         held_height_ff  <= '0;
         held_db_ff      <= slmb_pkg::MIN_DB_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         min_db_ff       <= min_db_in;
         max_db_ff       <= max_db_in;
         norm_scale_ff   <= norm_scale_in;
         attack_ff       <= attack_in;
         release_ff      <= release_in;
         target_left_ff  <= target_left_in;
         target_right_ff <= target_right_in;
         shown_left_ff   <= shown_left_in;
         shown_right_ff  <= shown_right_in;
         held_height_ff  <= held_height_in;
         held_db_ff      <= held_db_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Item and working registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_op_ff     <= slmb_pkg::op_type'(req_chan.operation);
         item_left_ff   <= req_chan.left_level;
         item_right_ff  <= req_chan.right_level;
         item_bypass_ff <= req_chan.bypass_on;
      end
      if (ctrl.db_store_l) begin
         db_left_ff <= db_from_product(product, item_left_ff == '0);
      end
      if (ctrl.db_store_r) begin
         db_right_ff <= db_from_product(product, item_right_ff == '0);
      end
      if (ctrl.norm_store_l) begin
         norm_left_ff <= normalize(db_left_ff, min_db_ff, max_db_ff, product[31:0]);
      end
      if (ctrl.acc_load) begin
         acc_ff <= acc_in;
      end
      if (ctrl.rsp_load) begin
         rsp_left_ff   <= shown_left_ff;
         rsp_right_ff  <= shown_right_ff;
         rsp_height_ff <= held_height_ff;
         rsp_db_ff     <= held_db_ff;
         rsp_over_ff   <= !held_db_ff[DB_W-1];
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.left_display  = rsp_left_ff;
   assign rsp_chan.right_display = rsp_right_ff;
   assign rsp_chan.peak_height   = rsp_height_ff;
   assign rsp_chan.peak_decibels = rsp_db_ff;
   assign rsp_chan.peak_over     = rsp_over_ff;

   // Terms watched by the assertions below.
   assign heights_ok   = (shown_left_ff <= slmb_pkg::FULL_SCALE)
                         && (shown_right_ff <= slmb_pkg::FULL_SCALE)
                         && (held_height_ff <= slmb_pkg::FULL_SCALE);
   assign target_write = ctrl.target_update || ctrl.misc_apply;

   // Heights never leave the Q1.16 full-scale range.
   `SLMB_ASSERT(a_height_range, heights_ok, "meter height above full scale")
   // Targets move only on a level update or a bypass.
   `SLMB_ASSERT_NEXT(a_target_source, !target_write, $stable(target_left_ff), "stray target change")
   // An accepted item keeps the block busy on the following cycle.
   `SLMB_ASSERT_NEXT(a_busy_after_accept, accept, !seq_ready, "ready right after an accept")

endmodule

FILE: bench/tb_stereo_level_meter_ballistics_unit.sv
`timescale 1ns / 1ps

// Self-checking bench of the stereo level meter ballistics unit: directed and random items,
// each checked against a bit-exact meter model, over several register settings.
// Depends on slmb_pkg, slmb_req_if, slmb_rsp_if and the unit's RTL.

module tb_stereo_level_meter_ballistics_unit;

   localparam int CLOCK_HALF      = 4;
   localparam int RESET_CYCLES    = 2;
   localparam int TABLE_DEPTH     = 64;
   localparam int FRAC_BITS       = 14;
   localparam int STALL_LIMIT     = 4000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 20;
   localparam int MAX_REPORTS     = 10;

   typedef struct {
      slmb_pkg::op_type op;
      logic [15:0]      left_level;
      logic [15:0]      right_level;
      logic             bypass_on;
   } meter_item_type;

   typedef struct {
      logic [slmb_pkg::HEIGHT_W-1:0]    left_display;
      logic [slmb_pkg::HEIGHT_W-1:0]    right_display;
      logic [slmb_pkg::HEIGHT_W-1:0]    peak_height;
      logic signed [slmb_pkg::DB_W-1:0] peak_decibels;
      logic                             peak_over;
   } meter_reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                             csr_write_enable;
   logic [slmb_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [slmb_pkg::CSR_DATA_W-1:0]  csr_write_data;

   slmb_req_if #(.LEVEL_BITS(16)) req_if ();
   slmb_rsp_if                    rsp_if ();

   stereo_level_meter_ballistics_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Stimulus and scoreboard storage.
   meter_item_type    meter_requests[$];
   meter_reading_type expected_readings[$];
   meter_item_type    offered_item;
   meter_item_type    accepted_item;
   int                mismatch_count = 0;
   int                quiet_cycles = 0;
   int                sender_idle_pct = 0;
   int                receiver_idle_pct = 0;
   int                hold_requests = 0;
   int                hold_served = 0;
   int                hold_left = 0;

   // Model copy of the registers and the meter state.
   logic [15:0]                      log2_frac_table [TABLE_DEPTH];
   logic signed [slmb_pkg::DB_W-1:0] cfg_min_db;
   logic [slmb_pkg::MAX_DB_W-1:0]    cfg_max_db;
   logic [slmb_pkg::COEFF_W-1:0]     cfg_norm_scale;
   logic [slmb_pkg::COEFF_W-1:0]     cfg_attack;
   logic [slmb_pkg::COEFF_W-1:0]     cfg_release;
   logic [slmb_pkg::HEIGHT_W-1:0]    tgt_left;
   logic [slmb_pkg::HEIGHT_W-1:0]    tgt_right;
   logic [slmb_pkg::HEIGHT_W-1:0]    disp_left;
   logic [slmb_pkg::HEIGHT_W-1:0]    disp_right;
   logic [slmb_pkg::HEIGHT_W-1:0]    hold_height;
   logic signed [slmb_pkg::DB_W-1:0] hold_db;

   always #(CLOCK_HALF) clock = ~clock;

   // Fractional log2 of 1 + step/DEPTH in Q0.16 by repeated squaring, truncated.
   function automatic logic [15:0] log2_fraction(int step);
      longint unsigned x;
      logic [15:0]     r;
      int              k;
      x = (longint'(TABLE_DEPTH + step) << 30) / TABLE_DEPTH;
      r = '0;
      for (k = 0; k < 16; k++) begin
         x = (x * x) >> 30;
         r = {r[14:0], 1'b0};
         if (x >= (64'd2 << 30)) begin
            x = x >> 1;
            r[0] = 1'b1;
         end
      end
      return r;
   endfunction

   // Linear Q2.14 magnitude to dB in Q8.8, rounded half up and saturated.
   function automatic logic signed [slmb_pkg::DB_W-1:0] to_decibels(logic [15:0] mag);
      int     lead;
      int     b;
      int     idx;
      longint l2;
      longint q;
      if (mag == '0)
         return slmb_pkg::DB_FLOOR;
      lead = 0;
      for (b = 0; b < 16; b++)
         if (mag[b])
            lead = b;
      idx = ((int'(mag) - (1 << lead)) * TABLE_DEPTH) >> lead;
      l2 = longint'(lead) * 65536 + longint'(log2_frac_table[idx])
           - longint'(FRAC_BITS) * 65536;
      q = (l2 * longint'(slmb_pkg::DB_PER_OCTAVE) + longint'(slmb_pkg::DB_ROUND)) >>> 24;
      if (q < longint'(slmb_pkg::DB_FLOOR))
         q = longint'(slmb_pkg::DB_FLOOR);
      if (q > longint'(slmb_pkg::DB_CEIL))
         q = longint'(slmb_pkg::DB_CEIL);
      return q[15:0];
   endfunction

   // Position of a dB value within the configured span, Q1.16 of full scale.
   function automatic logic [slmb_pkg::HEIGHT_W-1:0] normalize_db(
      logic signed [slmb_pkg::DB_W-1:0] db);
      longint v;
      if (int'(db) <= int'(cfg_min_db))
         return '0;
      if (int'(db) >= int'(cfg_max_db))
         return slmb_pkg::FULL_SCALE;
      v = (longint'(int'(db) - int'(cfg_min_db)) * longint'(cfg_norm_scale)) >> 8;
      if (v > longint'(slmb_pkg::FULL_SCALE))
         return slmb_pkg::FULL_SCALE;
      return v[slmb_pkg::HEIGHT_W-1:0];
   endfunction

   // One ballistics step of a shown level toward its target, with the snap to zero.
   function automatic logic [slmb_pkg::HEIGHT_W-1:0] smooth_level(
      logic [slmb_pkg::HEIGHT_W-1:0] old,
      logic [slmb_pkg::HEIGHT_W-1:0] tgt);
      longint unsigned o;
      longint unsigned t;
      longint unsigned c;
      longint unsigned v;
      o = old;
      t = tgt;
      c = (tgt > old) ? cfg_attack : cfg_release;
      v = (o * c + t * (65536 - c) + 32768) >> 16;
      if (v > slmb_pkg::FULL_SCALE)
         v = slmb_pkg::FULL_SCALE;
      if (v < slmb_pkg::SNAP_LIMIT)
         v = 0;
      return v[slmb_pkg::HEIGHT_W-1:0];
   endfunction

   // Applies one accepted item to the model and returns the reading it produces.
   function automatic meter_reading_type advance_meter(meter_item_type it);
      logic signed [slmb_pkg::DB_W-1:0] db_l;
      logic signed [slmb_pkg::DB_W-1:0] db_r;
      logic signed [slmb_pkg::DB_W-1:0] db_hi;
      logic [slmb_pkg::HEIGHT_W-1:0]    hi;
      meter_reading_type                r;
      case (it.op)
         slmb_pkg::OP_LEVEL: begin
            db_l = to_decibels(it.left_level);
            db_r = to_decibels(it.right_level);
            tgt_left = normalize_db(db_l);
            tgt_right = normalize_db(db_r);
            hi = (tgt_left > tgt_right) ? tgt_left : tgt_right;
            db_hi = (db_l > db_r) ? db_l : db_r;
            // Only a strictly higher peak replaces the held one.
            if (hi > hold_height) begin
               hold_height = hi;
               hold_db = db_hi;
            end
         end
         slmb_pkg::OP_TICK: begin
            disp_left = smooth_level(disp_left, tgt_left);
            disp_right = smooth_level(disp_right, tgt_right);
         end
         slmb_pkg::OP_PEAK_RESET: begin
            hold_height = '0;
            hold_db = cfg_min_db;
         end
         default: begin
            if (it.bypass_on) begin
               tgt_left = '0;
               tgt_right = '0;
            end
         end
      endcase
      r.left_display = disp_left;
      r.right_display = disp_right;
      r.peak_height = hold_height;
      r.peak_decibels = hold_db;
      r.peak_over = (hold_db >= 0);
      return r;
   endfunction

   // Compares a received reading with the oldest expected one.
   task automatic check_reading(meter_reading_type got);
      meter_reading_type want;
      if (expected_readings.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("Unexpected reading: left %0d right %0d peak %0d dB %0d over %0b",
                     got.left_display, got.right_display, got.peak_height,
                     got.peak_decibels, got.peak_over);
         return;
      end
      want = expected_readings.pop_front();
      if (got.left_display !== want.left_display || got.right_display !== want.right_display
          || got.peak_height !== want.peak_height
          || got.peak_decibels !== want.peak_decibels || got.peak_over !== want.peak_over)
      begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display({"Reading mismatch: expected left %0d right %0d peak %0d dB %0d ",
                      "over %0b, got left %0d right %0d peak %0d dB %0d over %0b"},
                     want.left_display, want.right_display, want.peak_height,
                     want.peak_decibels, want.peak_over, got.left_display,
                     got.right_display, got.peak_height, got.peak_decibels, got.peak_over);
      end
   endtask

   // Request driver: offers the next pending item once the previous one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.operation <= slmb_pkg::OP_LEVEL;
         req_if.left_level <= '0;
         req_if.right_level <= '0;
         req_if.bypass_on <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (meter_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            offered_item = meter_requests.pop_front();
            req_if.valid <= 1'b1;
            req_if.operation <= offered_item.op;
            req_if.left_level <= offered_item.left_level;
            req_if.right_level <= offered_item.right_level;
            req_if.bypass_on <= offered_item.bypass_on;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Response receiver: random back-pressure, plus long hold-offs on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_if.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_requests != hold_served) begin
         rsp_if.ready <= 1'b0;
         hold_served <= hold_served + 1;
         hold_left <= HOLD_OFF_CYCLES;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   // Monitor: checks each accepted reading and predicts each accepted item.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready)
            check_reading('{rsp_if.left_display, rsp_if.right_display, rsp_if.peak_height,
                            rsp_if.peak_decibels, rsp_if.peak_over});
         if (req_if.valid && req_if.ready) begin
            accepted_item.op = slmb_pkg::op_type'(req_if.operation);
            accepted_item.left_level = req_if.left_level;
            accepted_item.right_level = req_if.right_level;
            accepted_item.bypass_on = req_if.bypass_on;
            expected_readings.push_back(advance_meter(accepted_item));
         end
      end
   end

   // Watchdog on cycles in which no item moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_item(slmb_pkg::op_type op, logic [15:0] left, logic [15:0] right,
                           logic bypass);
      meter_item_type it;
      it.op = op;
      it.left_level = left;
      it.right_level = right;
      it.bypass_on = bypass;
      meter_requests.push_back(it);
   endtask

   // Magnitudes spread over the whole log range, with the extremes favored.
   function automatic logic [15:0] random_level();
      case ($urandom_range(0, 9))
         0:          return '0;
         1:          return '1;
         2, 3, 4, 5: return 16'($urandom_range(0, 65535));
         default:    return 16'($urandom >> $urandom_range(16, 31));
      endcase
   endfunction

   function automatic meter_item_type random_item();
      meter_item_type it;
      int             pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)
         it.op = slmb_pkg::OP_LEVEL;
      else if (pick < 60)
         it.op = slmb_pkg::OP_TICK;
      else if (pick < 80)
         it.op = slmb_pkg::OP_PEAK_RESET;
      else
         it.op = slmb_pkg::OP_BYPASS;
      it.left_level = random_level();
      // Mono sources repeat the left magnitude.
      it.right_level = ($urandom_range(0, 4) == 0) ? it.left_level : random_level();
      it.bypass_on = 1'($urandom_range(0, 1));
      return it;
   endfunction

   // Mostly level updates followed by a run of ticks, the rest single random items.
   task automatic queue_random_items(int count);
      meter_item_type it;
      int             queued;
      int             ticks;
      queued = 0;
      while (queued < count) begin
         if ($urandom_range(0, 9) < 7) begin
            it = random_item();
            it.op = slmb_pkg::OP_LEVEL;
            meter_requests.push_back(it);
            queued++;
            ticks = $urandom_range(1, 6);
            repeat (ticks) begin
               it = random_item();
               it.op = slmb_pkg::OP_TICK;
               meter_requests.push_back(it);
               queued++;
            end
         end else begin
            meter_requests.push_back(random_item());
            queued++;
         end
      end
   endtask

   // Waits until every item has been taken and every reading has come back.
   task automatic wait_until_drained();
      do
         @(negedge clock);
      while (meter_requests.size() != 0 || req_if.valid || expected_readings.size() != 0);
   endtask

   task automatic write_register(logic [slmb_pkg::CSR_INDEX_W-1:0] index,
                                 logic [slmb_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         slmb_pkg::REG_MIN_DB:     cfg_min_db = value;
         slmb_pkg::REG_MAX_DB:     cfg_max_db = value[slmb_pkg::MAX_DB_W-1:0];
         slmb_pkg::REG_NORM_SCALE: cfg_norm_scale = value;
         slmb_pkg::REG_ATTACK:     cfg_attack = value;
         slmb_pkg::REG_RELEASE:    cfg_release = value;
         default:                  ;
      endcase
   endtask

   // Writes every register; indexes past the last register get junk that must be ignored.
   task automatic set_meter_config(int min_v, int max_v, int norm_v, int atk_v, int rel_v);
      int idx;
      for (idx = int'(slmb_pkg::REG_RELEASE) + 1; idx < (1 << slmb_pkg::CSR_INDEX_W); idx++)
         write_register(idx[slmb_pkg::CSR_INDEX_W-1:0], 16'($urandom));
      write_register(slmb_pkg::REG_MIN_DB, 16'(min_v));
      write_register(slmb_pkg::REG_MAX_DB, 16'(max_v));
      write_register(slmb_pkg::REG_NORM_SCALE, 16'(norm_v));
      write_register(slmb_pkg::REG_ATTACK, 16'(atk_v));
      write_register(slmb_pkg::REG_RELEASE, 16'(rel_v));
      @(negedge clock);
   endtask

   // Main sequence: reset, then one phase per register setting.
   initial begin
      int i;
      int min_v;
      int max_v;
      int span;
      int norm_v;

      csr_write_enable = 1'b0;
      csr_index = slmb_pkg::REG_MIN_DB;
      csr_write_data = '0;

      for (i = 0; i < TABLE_DEPTH; i++)
         log2_frac_table[i] = log2_fraction(i);
      cfg_min_db = slmb_pkg::MIN_DB_RESET;
      cfg_max_db = slmb_pkg::MAX_DB_RESET;
      cfg_norm_scale = slmb_pkg::NORM_SCALE_RESET;
      cfg_attack = slmb_pkg::ATTACK_RESET;
      cfg_release = slmb_pkg::RELEASE_RESET;
      tgt_left = '0;
      tgt_right = '0;
      disp_left = '0;
      disp_right = '0;
      hold_height = '0;
      hold_db = slmb_pkg::MIN_DB_RESET;

      sender_idle_pct = 12;
      receiver_idle_pct = 76;

      // Directed items under the reset register values.
      add_item(slmb_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0);
      add_item(slmb_pkg::OP_LEVEL, 16'h0000, 16'h0000, 1'b1);
      add_item(slmb_pkg::OP_PEAK_RESET, 16'h0000, 16'h0000, 1'b0);
      add_item(slmb_pkg::OP_LEVEL, 16'h4000, 16'h0001, 1'b0);
      add_item(slmb_pkg::OP_LEVEL, 16'h0001, 16'h4000, 1'b1);
      add_item(slmb_pkg::OP_LEVEL, 16'hFFFF, 16'hFFFF, 1'b0);
      add_item(slmb_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0);
      add_item(slmb_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b1);
      add_item(slmb_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0);
      add_item(slmb_pkg::OP_BYPASS, 16'h1234, 16'h8765, 1'b0);
      add_item(slmb_pkg::OP_LEVEL, 16'h0001, 16'h0001, 1'b0);
      add_item(slmb_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0);
      add_item(slmb_pkg::OP_BYPASS, 16'hFFFF, 16'hFFFF, 1'b1);
      repeat (4)
         add_item(slmb_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0);
      add_item(slmb_pkg::OP_LEVEL, 16'h8000, 16'h0000, 1'b0);
      add_item(slmb_pkg::OP_LEVEL, 16'h5555, 16'hAAAA, 1'b1);
      add_item(slmb_pkg::OP_PEAK_RESET, 16'hFFFF, 16'hFFFF, 1'b1);
      add_item(slmb_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0);
      add_item(slmb_pkg::OP_LEVEL, 16'h0000, 16'hFFFF, 1'b0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      queue_random_items(60);
      wait_until_drained();

      // Widest span, attack that jumps at once, release that barely moves.
      set_meter_config(slmb_pkg::DB_FLOOR, 6144, 528, 0, 65535);
      queue_random_items(170);
      wait_until_drained();

      // Zero-width span at 0 dB with the coefficients swapped to their extremes.
      sender_idle_pct = 76;
      receiver_idle_pct = 12;
      set_meter_config(0, 0, 65535, 65535, 0);
      queue_random_items(120);
      wait_until_drained();

      // Oversized scale factor, so the normalized product saturates inside the span.
      set_meter_config(slmb_pkg::DB_FLOOR, 6144, 65535, $urandom_range(0, 65535),
                       $urandom_range(0, 65535));
      queue_random_items(150);
      wait_until_drained();

      // Zero scale factor, with a pause of the sender halfway through.
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      min_v = 0 - int'($urandom_range(0, 25600));
      max_v = $urandom_range(0, 6144);
      set_meter_config(min_v, max_v, 0, $urandom_range(0, 65535), $urandom_range(0, 65535));
      queue_random_items(75);
      wait_until_drained();
      queue_random_items(75);
      wait_until_drained();

      // Random span with its matching scale, while the receiver holds off for a while.
      min_v = 0 - int'($urandom_range(0, 25600));
      max_v = $urandom_range(0, 6144);
      span = max_v - min_v;
      norm_v = (span == 0) ? 1 : (1 << 24) / span;
      if (norm_v > 65535)
         norm_v = 65535;
      set_meter_config(min_v, max_v, norm_v, $urandom_range(0, 65535),
                       $urandom_range(0, 65535));
      queue_random_items(250);
      hold_requests = hold_requests + 1;
      wait_until_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_readings.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
